>>> sv/akd_pkg.sv
// Shared types and constants for the ANOVA kernel block.
`timescale 1ns / 1ps
`default_nettype none

package akd_pkg;

  // Highest kernel degree that the coefficient store holds
  localparam int MAX_DEGREE = 8;

  // Counter width that holds 0..MAX_DEGREE, and index width into the store
  localparam int K_W   = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  // Field widths
  localparam int FEAT_W = 16;
  localparam int DEG_W  = 4;
  localparam int COEF_W = 48;

  // Degree register value after reset
  localparam logic [DEG_W-1:0] DEG_RESET = 4'd2;

  // Arithmetic widths: |a|*|b| <= 2^30, magnitude of a coefficient <= 2^47
  localparam int FRAC_W = 24;
  localparam int PMAG_W = 2 * FEAT_W - 1;
  localparam int HALF_W = COEF_W - FRAC_W;
  localparam int LO_W   = PMAG_W + FRAC_W;
  localparam int HI_W   = PMAG_W + HALF_W;
  localparam int Q_W    = (LO_W > HI_W) ? LO_W : HI_W;
  localparam int TERM_W = COEF_W + 2;
  localparam int SUM_W  = COEF_W + 3;

  // 1.0 in Q23.24, rounding offset, and the term magnitude limit 2^48
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_W;
  localparam logic [LO_W-1:0]          RND_HALF = LO_W'(1) << (FRAC_W - 1);
  localparam logic [Q_W-1:0]           Q_LIM    = Q_W'(1) << COEF_W;

  // Input transaction
  typedef struct packed {
    logic signed [FEAT_W-1:0] feature_a;
    logic signed [FEAT_W-1:0] feature_b;
    logic                     last_element;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [COEF_W-1:0] kernel_value;
    logic                     saturated;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;       // take input pair, form |a*b|
    logic [IDX_W-1:0] rd_addr;    // coefficient store read address
    logic             abs_prev;   // take magnitude of e_{k-1}
    logic             unit_prev;  // e_{k-1} is the constant 1.0
    logic             mul_lo;     // low partial product, capture e_k
    logic             mul_hi;     // high partial product
    logic             scale;      // round, clamp and sign the term
    logic             acc;        // saturating add and write back
    logic [IDX_W-1:0] wr_addr;    // coefficient store write address
    logic             top;        // this write is e_d
    logic             emit;       // load result register, clear vector state
  } akd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [K_W-1:0] deg_eff;      // clamped degree
    logic           last;         // current pair closes the vector
    logic           out_free;     // result register can take a value
  } akd_sts_t;

endpackage

`default_nettype wire

>>> sv/akd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module akd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/akd_ctrl.sv
// Sequencer for the ANOVA kernel: walks k from d down to 1 per element pair.
`timescale 1ns / 1ps
`default_nettype none

module akd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire akd_pkg::akd_sts_t  sts,
  output      akd_pkg::akd_cmd_t  cmd
);
  import akd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_PREV,
    S_ABS,
    S_MUL_LO,
    S_MUL_HI,
    S_SCALE,
    S_ACC,
    S_EMIT
  } state_t;

  state_t         state;
  logic [K_W-1:0] k;
  logic [K_W-1:0] d;

  // Accept a pair only while idle
  assign in_stall = (state != S_IDLE);

  // Decode commands from state and degree counter
  always_comb begin
    cmd           = '0;
    cmd.rd_addr   = IDX_W'(k - K_W'(1));
    cmd.wr_addr   = IDX_W'(k - K_W'(1));
    cmd.unit_prev = (k == K_W'(1));
    cmd.top       = (k == d);
    unique case (state)
      S_IDLE:    cmd.load     = in_valid;
      S_RD_PREV: cmd.rd_addr  = IDX_W'(k - K_W'(2));
      S_ABS:     cmd.abs_prev = 1'b1;
      S_MUL_LO:  cmd.mul_lo   = 1'b1;
      S_MUL_HI:  cmd.mul_hi   = 1'b1;
      S_SCALE:   cmd.scale    = 1'b1;
      S_ACC:     cmd.acc      = 1'b1;
      S_EMIT:    cmd.emit     = sts.out_free;
      default:   cmd          = cmd;
    endcase
  end

  // Hold state, degree and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      d     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            k     <= sts.deg_eff;
            d     <= sts.deg_eff;
            state <= S_RD_PREV;
          end
        end
        S_RD_PREV: state <= S_ABS;
        S_ABS:     state <= S_MUL_LO;
        S_MUL_LO:  state <= S_MUL_HI;
        S_MUL_HI:  state <= S_SCALE;
        S_SCALE:   state <= S_ACC;
        S_ACC: begin
          if (k == K_W'(1)) begin
            state <= sts.last ? S_EMIT : S_IDLE;
          end else begin
            k     <= k - K_W'(1);
            state <= S_RD_PREV;
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/akd_datapath.sv
// Datapath: degree register, coefficient store, partial-product multipliers, result register.
`timescale 1ns / 1ps
`default_nettype none

module akd_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire akd_pkg::in_item_t            in_data,
  input  wire logic                         cfg_write,
  input  wire logic [akd_pkg::DEG_W-1:0]    cfg_data,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      akd_pkg::out_item_t           out_data,
  input  wire akd_pkg::akd_cmd_t            cmd,
  output      akd_pkg::akd_sts_t            sts
);
  import akd_pkg::*;

  logic [DEG_W-1:0]         degree;
  logic [MAX_DEGREE-1:0]    coef_vld;
  logic                     rd_vld;
  logic                     sticky;
  logic                     last_q;

  logic [PMAG_W-1:0]        pmag;
  logic                     psign;
  logic [COEF_W-1:0]        emag;
  logic                     neg;
  logic signed [COEF_W-1:0] cur;
  logic [LO_W-1:0]          lo;
  logic [HI_W-1:0]          hi;
  logic signed [TERM_W-1:0] term;
  logic                     term_sat;
  logic signed [COEF_W-1:0] res_val;

  logic [FEAT_W-1:0]        amag;
  logic [FEAT_W-1:0]        bmag;
  logic signed [COEF_W-1:0] rdata;
  logic signed [COEF_W-1:0] prev;
  logic [Q_W-1:0]           q;
  logic [Q_W-1:0]           q_clamp;
  logic [TERM_W-1:0]        tmag;
  logic signed [SUM_W-1:0]  sum;
  logic signed [COEF_W-1:0] sum_sat;
  logic                     sum_ovf;

  // Clamp the programmed degree into 1..MAX_DEGREE; report status
  always_comb begin
    sts.last     = last_q;
    sts.out_free = !out_valid || !out_stall;
    if (degree == '0) begin
      sts.deg_eff = K_W'(1);
    end else if (32'(degree) > 32'(MAX_DEGREE)) begin
      sts.deg_eff = K_W'(MAX_DEGREE);
    end else begin
      sts.deg_eff = K_W'(degree);
    end
  end

  // Coefficient store
  akd_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_DEGREE)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (cmd.wr_addr),
    .wdata (sum_sat),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  // Input magnitudes
  assign amag = in_data.feature_a[FEAT_W-1] ? (~in_data.feature_a + 1'b1)
                                           : in_data.feature_a;
  assign bmag = in_data.feature_b[FEAT_W-1] ? (~in_data.feature_b + 1'b1)
                                           : in_data.feature_b;

  // Select e_{k-1}: constant 1.0, stored value, or zero if never written
  always_comb begin
    if (cmd.unit_prev) begin
      prev = COEF_ONE;
    end else if (rd_vld) begin
      prev = rdata;
    end else begin
      prev = '0;
    end
  end

  // Combine partial products with rounding, clamp magnitude at 2^48
  assign q       = Q_W'(hi) + Q_W'(lo[LO_W-1:FRAC_W]);
  assign q_clamp = (q > Q_LIM) ? Q_LIM : q;
  assign tmag    = TERM_W'(q_clamp);

  // Saturating accumulate into e_k
  assign sum     = SUM_W'(cur) + SUM_W'(term);
  always_comb begin
    sum_ovf = 1'b0;
    sum_sat = sum[COEF_W-1:0];
    if (!sum[SUM_W-1] && (sum[SUM_W-2:COEF_W-1] != '0)) begin
      sum_ovf = 1'b1;
      sum_sat = {1'b0, {(COEF_W-1){1'b1}}};
    end else if (sum[SUM_W-1] && (sum[SUM_W-2:COEF_W-1] != '1)) begin
      sum_ovf = 1'b1;
      sum_sat = {1'b1, {(COEF_W-1){1'b0}}};
    end
  end

  // Payload pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pmag   <= PMAG_W'(amag) * PMAG_W'(bmag);
      psign  <= in_data.feature_a[FEAT_W-1] ^ in_data.feature_b[FEAT_W-1];
      last_q <= in_data.last_element;
    end
    if (cmd.abs_prev) begin
      emag <= prev[COEF_W-1] ? (~prev + 1'b1) : prev;
      neg  <= psign ^ prev[COEF_W-1];
    end
    if (cmd.mul_lo) begin
      lo  <= (LO_W'(pmag) * LO_W'(emag[FRAC_W-1:0])) + RND_HALF;
      cur <= rd_vld ? rdata : '0;
    end
    if (cmd.mul_hi) begin
      hi <= HI_W'(pmag) * HI_W'(emag[COEF_W-1:FRAC_W]);
    end
    if (cmd.scale) begin
      term     <= neg ? -$signed(tmag) : $signed(tmag);
      term_sat <= (q > Q_LIM);
    end
    if (cmd.acc && cmd.top) begin
      res_val <= sum_sat;
    end
    if (cmd.emit) begin
      out_data.kernel_value <= res_val;
      out_data.saturated    <= sticky;
    end
  end

  // Control registers: degree, valid bits, sticky flag, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      degree    <= DEG_RESET;
      coef_vld  <= '0;
      rd_vld    <= 1'b0;
      sticky    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        degree <= cfg_data;
      end
      rd_vld <= coef_vld[cmd.rd_addr];
      if (cmd.emit) begin
        coef_vld <= '0;
        sticky   <= 1'b0;
      end else if (cmd.acc) begin
        coef_vld[cmd.wr_addr] <= 1'b1;
        sticky <= sticky | term_sat | sum_ovf;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/anova_kernel_dp.sv
// Top level of the streaming degree-d ANOVA kernel.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------------
//  input    | in_valid / in_stall            | in_data  (feature_a, feature_b,
//           |                                |           last_element)
//  output   | out_valid / out_stall          | out_data (kernel_value, saturated)
//  config   | cfg_write                      | cfg_data (degree)
//
//  Each element pair enters at S_IDLE and updates d coefficients, d being the
//  clamped degree: every coefficient update reads e_{k-1} and e_k through the
//  registered read port of the coefficient RAM and forms the term as two 31x24
//  partial products, six steps per coefficient. A closing pair adds S_EMIT to
//  move the result into the output register, waiting while out_stall holds it.
//  Reset clears the sequencer, coefficient valid bits and sticky flag; degree
//  returns to 2. A result waits in the output register under out_stall; the
//  input stalls while a pair is in progress or a result is blocked behind it.
`timescale 1ns / 1ps
`default_nettype none

module anova_kernel_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire akd_pkg::in_item_t          in_data,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      akd_pkg::out_item_t         out_data,
  input  wire logic                       cfg_write,
  input  wire logic [akd_pkg::DEG_W-1:0]  cfg_data
);
  import akd_pkg::*;

  akd_cmd_t cmd;
  akd_sts_t sts;

  akd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  akd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // An accepted transaction closes the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // A result appears only through the emit command
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result valid without emit");

  // Emit happens only for a pair that closes its vector
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.last)
    else $error("emit on a pair that is not last");

  // Coefficient write-back never coincides with taking a new pair
  a_acc_not_load: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> (in_stall && !cmd.load))
    else $error("accumulate while idle");

endmodule

`default_nettype wire
